FILE: rtl/tlt_pkg.sv
package tlt_pkg;

  localparam int CNT_W = 6;
  localparam logic [7:0] EMPTY_TYPE = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_ADD    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_ERASE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECTED = 2'd1,
    ST_PENDING  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t         opcode;
    logic [7:0]  label_type;
    logic [15:0] label_value;
    logic        last_in_batch;
    logic [7:0]  read_limit;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        entry_type;
    logic [15:0]       entry_value;
    logic [CNT_W-1:0]  stored_entries;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  etype;
    logic [15:0] evalue;
  } entry_t;

  // ring control from the sequencer to the cell row
  typedef struct packed {
    logic   shift;
    entry_t fb;
  } ring_ctl_t;

endpackage

FILE: rtl/tlt_cell.sv
module tlt_cell (
  input  logic            clk,
  input  logic            shift,
  input  tlt_pkg::entry_t din,
  output tlt_pkg::entry_t dout
);

  tlt_pkg::entry_t ent_r;

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      ent_r <= din;
    end
  end

  assign dout = ent_r;

endmodule

FILE: rtl/tlt_ctrl.sv
module tlt_ctrl #(
  parameter int MAX_ENTRIES = 42
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  tlt_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  output tlt_pkg::out_item_t out_data,
  input  logic               out_stall,
  input  tlt_pkg::entry_t    head,
  output tlt_pkg::ring_ctl_t ring
);

  localparam int W = tlt_pkg::CNT_W;
  localparam logic [W-1:0] LAST_STEP = W'(MAX_ENTRIES - 1);

  tlt_pkg::state_t    state_r, state_nxt;
  logic [W-1:0]       k_r, k_nxt;
  tlt_pkg::op_t       op_r, op_nxt;
  logic [7:0]         ty_r, ty_nxt;
  logic [15:0]        val_r, val_nxt;
  logic               last_r, last_nxt;
  logic [W-1:0]       n_r, n_nxt;
  logic [W-1:0]       used_r, used_nxt;
  logic               match_r, match_nxt;
  logic               ins_r, ins_nxt;
  logic [W-1:0]       committed_r, committed_nxt;
  logic [W-1:0]       staged_r, staged_nxt;
  logic               rej_r, rej_nxt;
  logic               out_valid_r, out_valid_nxt;
  tlt_pkg::out_item_t out_data_r, out_data_nxt;

  logic         out_free, in_acc, hit, scan_emit, advance, scan_end;
  logic [W-1:0] n_in;
  logic         rej_after;
  logic [W-1:0] staged_after;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && (state_r == tlt_pkg::S_IDLE) && out_free;
  assign in_stall  = !((state_r == tlt_pkg::S_IDLE) && out_free);
  assign hit       = (head.etype == ty_r);
  assign scan_emit = (op_r == tlt_pkg::OP_READ) && (k_r < n_r);
  assign advance   = (state_r == tlt_pkg::S_SCAN) && (!scan_emit || out_free);
  assign scan_end  = advance && (k_r == LAST_STEP);
  assign n_in      = ({2'b00, committed_r} < in_data.read_limit) ? committed_r
                                                                 : in_data.read_limit[W-1:0];
  assign rej_after    = rej_r || !ins_r;
  assign staged_after = staged_r + {{(W-1){1'b0}}, ins_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlt_pkg::S_IDLE: begin
        if (in_acc && (in_data.opcode != tlt_pkg::OP_ERASE) &&
            !((in_data.opcode == tlt_pkg::OP_READ) && (n_in == '0))) begin
          state_nxt = tlt_pkg::S_SCAN;
        end
      end
      tlt_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = (op_r == tlt_pkg::OP_READ) ? tlt_pkg::S_IDLE : tlt_pkg::S_RESP;
        end
      end
      tlt_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = tlt_pkg::S_IDLE;
        end
      end
      default: state_nxt = tlt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    k_nxt         = k_r;
    op_nxt        = op_r;
    ty_nxt        = ty_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    n_nxt         = n_r;
    used_nxt      = used_r;
    match_nxt     = match_r;
    ins_nxt       = ins_r;
    committed_nxt = committed_r;
    staged_nxt    = staged_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ring.shift    = advance;
    ring.fb       = head;

    unique case (state_r)
      tlt_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_data.opcode;
          ty_nxt    = in_data.label_type;
          val_nxt   = in_data.label_value;
          last_nxt  = in_data.last_in_batch;
          n_nxt     = n_in;
          used_nxt  = committed_r + staged_r;
          match_nxt = 1'b0;
          ins_nxt   = 1'b0;
          k_nxt     = '0;
          if (in_data.opcode == tlt_pkg::OP_ERASE) begin
            committed_nxt = '0;
            staged_nxt    = '0;
            rej_nxt       = 1'b0;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{tlt_pkg::ST_OK, 8'd0, 16'd0, '0, 1'b1};
          end else if ((in_data.opcode == tlt_pkg::OP_READ) && (n_in == '0)) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{tlt_pkg::ST_EMPTY, 8'd0, 16'd0, committed_r, 1'b1};
          end
        end
      end
      tlt_pkg::S_SCAN: begin
        if (advance) begin
          k_nxt = k_r + W'(1);
          unique case (op_r)
            tlt_pkg::OP_READ: begin
              if (scan_emit) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{tlt_pkg::ST_OK, head.etype, head.evalue, committed_r,
                                  (k_r == n_r - W'(1))};
              end
            end
            tlt_pkg::OP_ADD: begin
              if ((k_r < used_r) && hit) begin
                match_nxt = 1'b1;
              end
              // the insert slot comes after every slot the duplicate check covers
              if ((k_r == used_r) && !rej_r && (ty_r != tlt_pkg::EMPTY_TYPE) && !match_r) begin
                ring.fb = '{ty_r, val_r};
                ins_nxt = 1'b1;
              end
            end
            tlt_pkg::OP_UPDATE: begin
              if ((k_r < committed_r) && hit && (ty_r != tlt_pkg::EMPTY_TYPE)) begin
                ring.fb.evalue = val_r;
                match_nxt      = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      tlt_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (op_r == tlt_pkg::OP_ADD) begin
            if (last_r) begin
              if (!rej_after) begin
                committed_nxt = committed_r + staged_after;
              end
              staged_nxt   = '0;
              rej_nxt      = 1'b0;
              out_data_nxt = '{rej_after ? tlt_pkg::ST_REJECTED : tlt_pkg::ST_OK, 8'd0, 16'd0,
                               rej_after ? committed_r : committed_r + staged_after, 1'b1};
            end else begin
              staged_nxt   = staged_after;
              rej_nxt      = rej_after;
              out_data_nxt = '{tlt_pkg::ST_PENDING, 8'd0, 16'd0, committed_r, 1'b1};
            end
          end else begin
            out_data_nxt = '{match_r ? tlt_pkg::ST_OK : tlt_pkg::ST_REJECTED, 8'd0, 16'd0,
                             committed_r, 1'b1};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlt_pkg::S_IDLE;
      committed_r <= '0;
      staged_r    <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      committed_r <= committed_nxt;
      staged_r    <= staged_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    op_r       <= op_nxt;
    ty_r       <= ty_nxt;
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    n_r        <= n_nxt;
    used_r     <= used_nxt;
    match_r    <= match_nxt;
    ins_r      <= ins_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/typed_label_table_unit.sv
// typed label table: packed table of up to MAX_ENTRIES typed 16-bit labels
// input channel in_valid / in_stall / in_data carries one command transaction
// (read, add, update, erase); output channel out_valid / out_stall / out_data
// returns result transactions, last_result marks the final one of a command
// entries live in a ring of cells that rotates one slot per cycle past a
// single compare point; read, add and update take one full turn of the ring
// read emits one transaction per committed entry, up to read_limit, as its
// slot passes the head, and the ring pauses while a read result waits on
// out_stall; erase and an empty read answer in the cycle after acceptance;
// add and update scan the whole ring and then answer from the response state
// through the output register; a read result also goes through the output
// register, and further results follow one per cycle unless out_stall holds
// the output; add, update and read are paced by the ring rotation
// one command at a time: in_stall stays high until the command is finished
// and the output register can take its result
// reset (rst_n low, synchronous) clears counts, pending batch and the output
// valid flag; cell contents need no reset since only written slots are read
module typed_label_table_unit #(
  parameter int MAX_ENTRIES = 42
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tlt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tlt_pkg::out_item_t out_data
);

  // cell i hands its entry to cell i-1; the head (cell 0) feeds the sequencer
  tlt_pkg::entry_t    cell_q [MAX_ENTRIES];
  tlt_pkg::entry_t    cell_d [MAX_ENTRIES];
  tlt_pkg::ring_ctl_t ring;

  tlt_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall),
    .head     (cell_q[0]),
    .ring     (ring)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    // tail cell closes the ring through the sequencer, which may swap in a
    // new label or a rewritten value
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign cell_d[i] = ring.fb;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end

    tlt_cell u_cell (
      .clk  (clk),
      .shift(ring.shift),
      .din  (cell_d[i]),
      .dout (cell_q[i])
    );
  end

endmodule
